// ===== rtl/positional_array_list_defines.svh =====
// assertion macros for the positional array list
// used by the top level only; expects clk and rst_n in scope
`ifndef POSITIONAL_ARRAY_LIST_DEFINES_SVH
`define POSITIONAL_ARRAY_LIST_DEFINES_SVH

// condition holds at every clock edge out of reset
`define PAL_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// trigger implies consequence in the same cycle
`define PAL_ASSERT_SAME(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) else $error(msg);

// trigger implies consequence in the next cycle
`define PAL_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

// ===== rtl/pal_pkg.sv =====
// shared types and codes for the positional array list
// no dependencies
package pal_pkg;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  // what the sequencer has to do for one transaction
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_READ,
    ACT_APPEND,
    ACT_SHIFT_UP,
    ACT_TAKE_LAST,
    ACT_SHIFT_DOWN
  } act_t;

  typedef struct packed {
    status_t status;
    act_t    act;
  } plan_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SHIFT,
    S_PLACE,
    S_RESP
  } state_t;

endpackage

// ===== rtl/positional_array_list.sv =====
// positional array list top level: sequencer, entry memory, result register
// depends on pal_pkg, pal_decode and positional_array_list_defines.svh
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------------------
//   in_      | in_valid / in_ready  | in_mode, in_position, in_entry_data
//   out_     | out_valid / out_ready| out_status, out_read_data, out_entry_count
//
// one transaction at a time; a single-port-pair memory moves one entry per cycle
// read, append, remove of the last entry and any rejected request go straight to the reply
// remove at p shifts the entries above p down; insert at p < count shifts entries up, then places
// the new entry; the worst case is set by the one-entry-per-cycle shift loop
// reset clears count and control only; entries need no clearing pass
// a result waiting on out_ready holds the block in S_RESP and blocks the next transaction
`include "positional_array_list_defines.svh"

module positional_array_list #(
  parameter int DEPTH      = 16,
  parameter int ENTRY_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [4:0]  in_position,
  input  logic [31:0] in_entry_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_read_data,
  output logic [4:0]  out_entry_count
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // entry storage, one write and one registered read per cycle
  logic [ENTRY_BITS-1:0] mem [DEPTH];
  logic [ENTRY_BITS-1:0] rd_q_r;

  pal_pkg::state_t state_r, state_nxt;
  pal_pkg::plan_t  plan;

  logic [CW-1:0]         count_r, count_nxt;
  logic [AW-1:0]         idx_r, idx_nxt;     // address of the last read issued
  logic [AW-1:0]         end_r, end_nxt;     // last address the shift reads
  logic                  up_r, up_nxt;       // shift direction: insert moves entries up
  logic [ENTRY_BITS-1:0] data_r, data_nxt;   // entry held for the final insert write
  pal_pkg::status_t      res_status_r, res_status_nxt;
  logic                  res_rd_r, res_rd_nxt;

  logic                  out_valid_r;
  logic [1:0]            out_status_r;
  logic [31:0]           out_read_data_r;
  logic [4:0]            out_entry_count_r;

  logic                  in_fire;
  logic                  out_load;
  logic                  last_move;
  logic [AW-1:0]         pos_a;
  logic [AW-1:0]         cnt_m1;
  logic                  fail_out;

  logic                  mem_we;
  logic [AW-1:0]         wr_addr;
  logic [ENTRY_BITS-1:0] wr_data;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [63:0]           rd_q_wide;

  pal_decode #(
    .DEPTH (DEPTH)
  ) u_decode (
    .mode     (in_mode),
    .position (in_position),
    .count    (count_r),
    .plan     (plan)
  );

  assign in_fire   = in_valid && in_ready;
  assign out_load  = (state_r == pal_pkg::S_RESP) && (!out_valid_r || out_ready);
  assign last_move = (idx_r == end_r);
  // position is already checked against count whenever it addresses memory
  assign pos_a     = AW'(in_position);
  assign cnt_m1    = AW'(count_r - CW'(1));
  assign rd_q_wide = 64'(rd_q_r);
  // a failed transaction is on the output
  assign fail_out  = out_valid_r && (out_status_r != pal_pkg::ST_OK);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pal_pkg::S_IDLE: begin
        if (in_fire) begin
          if (plan.act == pal_pkg::ACT_SHIFT_UP || plan.act == pal_pkg::ACT_SHIFT_DOWN) begin
            state_nxt = pal_pkg::S_SHIFT;
          end else begin
            state_nxt = pal_pkg::S_RESP;
          end
        end
      end
      pal_pkg::S_SHIFT: begin
        if (last_move) begin
          state_nxt = up_r ? pal_pkg::S_PLACE : pal_pkg::S_RESP;
        end
      end
      pal_pkg::S_PLACE: begin
        state_nxt = pal_pkg::S_RESP;
      end
      pal_pkg::S_RESP: begin
        if (out_load) begin
          state_nxt = pal_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = pal_pkg::S_IDLE;
      end
    endcase
  end

  // memory commands and datapath updates
  always_comb begin
    in_ready       = 1'b0;
    mem_we         = 1'b0;
    wr_addr        = idx_r;
    wr_data        = rd_q_r;
    rd_en          = 1'b0;
    rd_addr        = idx_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    end_nxt        = end_r;
    up_nxt         = up_r;
    data_nxt       = data_r;
    res_status_nxt = res_status_r;
    res_rd_nxt     = res_rd_r;
    case (state_r)
      pal_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          res_status_nxt = plan.status;
          res_rd_nxt     = (plan.act == pal_pkg::ACT_READ);
          data_nxt       = ENTRY_BITS'(in_entry_data);
          case (plan.act)
            pal_pkg::ACT_READ: begin
              rd_en   = 1'b1;
              rd_addr = pos_a;
            end
            pal_pkg::ACT_APPEND: begin
              mem_we    = 1'b1;
              wr_addr   = pos_a;
              wr_data   = ENTRY_BITS'(in_entry_data);
              count_nxt = count_r + CW'(1);
            end
            pal_pkg::ACT_SHIFT_UP: begin
              // walk down from the tail, each entry lands one slot higher
              rd_en     = 1'b1;
              rd_addr   = cnt_m1;
              idx_nxt   = cnt_m1;
              end_nxt   = pos_a;
              up_nxt    = 1'b1;
              count_nxt = count_r + CW'(1);
            end
            pal_pkg::ACT_TAKE_LAST: begin
              count_nxt = count_r - CW'(1);
            end
            pal_pkg::ACT_SHIFT_DOWN: begin
              // walk up from the slot after the hole, each entry lands one lower
              rd_en     = 1'b1;
              rd_addr   = pos_a + AW'(1);
              idx_nxt   = pos_a + AW'(1);
              end_nxt   = cnt_m1;
              up_nxt    = 1'b0;
              count_nxt = count_r - CW'(1);
            end
            default: begin
              rd_en = 1'b0;
            end
          endcase
        end
      end
      pal_pkg::S_SHIFT: begin
        // write back the entry read last cycle; the target was already read
        mem_we  = 1'b1;
        wr_addr = up_r ? (idx_r + AW'(1)) : (idx_r - AW'(1));
        wr_data = rd_q_r;
        if (!last_move) begin
          rd_en   = 1'b1;
          rd_addr = up_r ? (idx_r - AW'(1)) : (idx_r + AW'(1));
          idx_nxt = rd_addr;
        end
      end
      pal_pkg::S_PLACE: begin
        mem_we  = 1'b1;
        wr_addr = end_r;
        wr_data = data_r;
      end
      pal_pkg::S_RESP: begin
        in_ready = 1'b0;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pal_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    end_r        <= end_nxt;
    up_r         <= up_nxt;
    data_r       <= data_nxt;
    res_status_r <= res_status_nxt;
    res_rd_r     <= res_rd_nxt;
    if (out_load) begin
      out_status_r      <= res_status_r;
      out_read_data_r   <= res_rd_r ? rd_q_wide[31:0] : 32'd0;
      out_entry_count_r <= 5'(count_r);
    end
  end

  // entry memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_read_data   = out_read_data_r;
  assign out_entry_count = out_entry_count_r;

  // checks
  `PAL_ASSERT_ALWAYS(a_count_bound, count_r <= CW'(DEPTH), "entry count above depth")
  `PAL_ASSERT_NEXT(a_write_in_list, mem_we, CW'($past(wr_addr)) < count_r, "write outside list")
  `PAL_ASSERT_SAME(a_read_in_list, rd_en, CW'(rd_addr) <= count_r, "read beyond list end")
  `PAL_ASSERT_SAME(a_fail_no_data, fail_out, out_read_data_r == 32'd0, "data on failed reply")

endmodule

// ===== rtl/pal_decode.sv =====
// request check: status and memory action from mode, position and count
// depends on pal_pkg
module pal_decode #(
  parameter int DEPTH = 16
) (
  input  logic [1:0]                   mode,
  input  logic [4:0]                   position,
  input  logic [$clog2(DEPTH+1)-1:0]   count,
  output pal_pkg::plan_t               plan
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > 5) ? CW : 5;

  logic [XW-1:0] pos_x;
  logic [XW-1:0] cnt_x;
  logic          empty;
  logic          full;

  assign pos_x = XW'(position);
  assign cnt_x = XW'(count);
  assign empty = (count == '0);
  assign full  = (count == CW'(DEPTH));

  always_comb begin
    plan.status = pal_pkg::ST_BADPOS;
    plan.act    = pal_pkg::ACT_NONE;
    case (mode)
      pal_pkg::MODE_INSERT: begin
        if (full) begin
          plan.status = pal_pkg::ST_FULL;
        end else if (pos_x > cnt_x) begin
          plan.status = pal_pkg::ST_BADPOS;
        end else begin
          plan.status = pal_pkg::ST_OK;
          plan.act    = (pos_x == cnt_x) ? pal_pkg::ACT_APPEND : pal_pkg::ACT_SHIFT_UP;
        end
      end
      pal_pkg::MODE_REMOVE: begin
        if (empty) begin
          plan.status = pal_pkg::ST_EMPTY;
        end else if (pos_x >= cnt_x) begin
          plan.status = pal_pkg::ST_BADPOS;
        end else begin
          plan.status = pal_pkg::ST_OK;
          plan.act    = (pos_x + XW'(1) == cnt_x) ? pal_pkg::ACT_TAKE_LAST
                                                  : pal_pkg::ACT_SHIFT_DOWN;
        end
      end
      pal_pkg::MODE_READ: begin
        if (empty) begin
          plan.status = pal_pkg::ST_EMPTY;
        end else if (pos_x >= cnt_x) begin
          plan.status = pal_pkg::ST_BADPOS;
        end else begin
          plan.status = pal_pkg::ST_OK;
          plan.act    = pal_pkg::ACT_READ;
        end
      end
      default: begin
        plan.status = pal_pkg::ST_BADPOS;
        plan.act    = pal_pkg::ACT_NONE;
      end
    endcase
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// self-checking testbench for positional_array_list: directed and random list requests
// depends on pal_pkg and the positional_array_list rtl; predicts every reply in-line
`timescale 1ns / 1ps

module tb_top;

  // ---------------------------------------------------------------------------
  // run constants
  // ---------------------------------------------------------------------------
  localparam int LIST_DEPTH   = 16;
  localparam int ENTRY_W      = 32;
  localparam int CYCLE_LIMIT  = 400000;       // far above the slowest legal run
  localparam int DRAIN_CYCLES = 2 * LIST_DEPTH + 8;
  localparam int HOLD_CYCLES  = 200;          // long receiver hold-off
  localparam int PRINT_CAP    = 40;           // mismatch lines printed before going quiet
  localparam int RANDOM_ITEMS = 820;
  localparam int PHASE_COUNT  = 8;

  // the one mode value the package leaves unnamed
  localparam logic [1:0] MODE_SPARE = 2'd3;

  // one reply as the block returns it
  typedef struct packed {
    pal_pkg::status_t       status;
    logic [31:0]            read_data;
    logic [4:0]             entry_count;
  } list_reply_t;

  // ---------------------------------------------------------------------------
  // dut signals; the inputs are known from time zero
  // ---------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_mode = pal_pkg::MODE_INSERT;
  logic [4:0]  in_position = 5'd0;
  logic [31:0] in_entry_data = 32'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [31:0] out_read_data;
  logic [4:0]  out_entry_count;

  positional_array_list #(
    .DEPTH      (LIST_DEPTH),
    .ENTRY_BITS (ENTRY_W)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_position     (in_position),
    .in_entry_data   (in_entry_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_read_data   (out_read_data),
    .out_entry_count (out_entry_count)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // shadow copy of the list and the replies still owed by the block
  // ---------------------------------------------------------------------------
  logic [ENTRY_W-1:0] shadow_entries [LIST_DEPTH];
  int                 shadow_count = 0;
  list_reply_t        awaited_replies [$];

  int error_count     = 0;
  int replies_checked = 0;
  int accepted_count  = 0;
  int mode_tally   [4] = '{0, 0, 0, 0};
  int status_tally [4] = '{0, 0, 0, 0};
  int cycle_count     = 0;

  // idling controls: steady flags are set at a rising edge, read at falling edges
  bit src_steady   = 1'b0;
  bit sink_steady  = 1'b0;
  int hold_request = 0;
  int sink_wait    = 0;

  // apply one request to the shadow list and return the reply it must produce
  function automatic list_reply_t apply_list_request(input logic [1:0] mode,
                                                     input logic [4:0] pos,
                                                     input logic [31:0] data);
    list_reply_t reply;
    int          i;
    reply.status    = pal_pkg::ST_BADPOS;
    reply.read_data = '0;
    case (mode)
      pal_pkg::MODE_INSERT: begin
        // fullness wins over a bad position
        if (shadow_count >= LIST_DEPTH) begin
          reply.status = pal_pkg::ST_FULL;
        end else if (int'(pos) > shadow_count) begin
          reply.status = pal_pkg::ST_BADPOS;
        end else begin
          for (i = shadow_count; i > int'(pos); i--) begin
            shadow_entries[i] = shadow_entries[i-1];
          end
          shadow_entries[pos] = data[ENTRY_W-1:0];
          shadow_count++;
          reply.status = pal_pkg::ST_OK;
        end
      end
      pal_pkg::MODE_REMOVE: begin
        // emptiness wins over a bad position
        if (shadow_count == 0) begin
          reply.status = pal_pkg::ST_EMPTY;
        end else if (int'(pos) >= shadow_count) begin
          reply.status = pal_pkg::ST_BADPOS;
        end else begin
          for (i = int'(pos); i + 1 < shadow_count; i++) begin
            shadow_entries[i] = shadow_entries[i+1];
          end
          shadow_count--;
          reply.status = pal_pkg::ST_OK;
        end
      end
      pal_pkg::MODE_READ: begin
        if (shadow_count == 0) begin
          reply.status = pal_pkg::ST_EMPTY;
        end else if (int'(pos) >= shadow_count) begin
          reply.status = pal_pkg::ST_BADPOS;
        end else begin
          reply.read_data = 32'(shadow_entries[pos]);
          reply.status    = pal_pkg::ST_OK;
        end
      end
      default: begin
        // unused mode: list untouched, bad position reported
        reply.status = pal_pkg::ST_BADPOS;
      end
    endcase
    reply.entry_count = 5'(shadow_count);
    return reply;
  endfunction

  // one line per mismatch, quiet after the cap, always counted
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    if (error_count <= PRINT_CAP) begin
      $display("[%0t] mismatch %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    end
  endtask

  // ---------------------------------------------------------------------------
  // scoreboard: replies are checked first, then an accepted transaction is
  // predicted, all in one process so the queue order is fixed
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    list_reply_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_replies.size() == 0) begin
        report_mismatch("reply with nothing awaited, status", 32'(out_status), 32'd0);
      end else begin
        want = awaited_replies.pop_front();
        replies_checked++;
        if (out_status !== want.status) begin
          report_mismatch("status", 32'(out_status), 32'(want.status));
        end
        if (out_read_data !== want.read_data) begin
          report_mismatch("read_data", out_read_data, want.read_data);
        end
        if (out_entry_count !== want.entry_count) begin
          report_mismatch("entry_count", 32'(out_entry_count), 32'(want.entry_count));
        end
      end
    end
    if (rst_n && in_valid && in_ready) begin
      want = apply_list_request(in_mode, in_position, in_entry_data);
      awaited_replies.push_back(want);
      accepted_count++;
      mode_tally[in_mode]++;
      status_tally[want.status]++;
    end
  end

  // watchdog on total cycles
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies still awaited",
               cycle_count, awaited_replies.size());
      $display("positional_array_list regression: fail");
      $finish;
    end
  end

  // gap lengths: mostly none or short, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // entry values with the extremes showing up often
  function automatic logic [31:0] pick_entry();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'h0000_0000;
    if (r == 1) return 32'hFFFF_FFFF;
    return $urandom();
  endfunction

  // ---------------------------------------------------------------------------
  // receiver: random stalls, steady stretches, and a long hold-off on request,
  // counted here in its own process
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_request != 0) begin
      sink_wait    = hold_request;
      hold_request = 0;
    end
    if (!rst_n) begin
      out_ready = 1'b0;
    end else if (sink_wait > 0) begin
      out_ready = 1'b0;
      sink_wait--;
    end else if (sink_steady) begin
      out_ready = 1'b1;
    end else begin
      sink_wait = pick_gap();
      if (sink_wait > 0) begin
        out_ready = 1'b0;
        sink_wait--;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender side: called at a falling edge, returns at a falling edge; valid
  // stays high between back-to-back transactions
  // ---------------------------------------------------------------------------
  task automatic send_request(input logic [1:0] mode, input logic [4:0] pos,
                              input logic [31:0] data);
    int gap;
    in_mode       = mode;
    in_position   = pos;
    in_entry_data = data;
    in_valid      = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    gap = src_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // sender pauses until the block has answered everything
  task automatic wait_all_replies();
    in_valid = 1'b0;
    while (awaited_replies.size() != 0) @(negedge clk);
  endtask

  // change idling style at a rising edge so the receiver sees it cleanly
  task automatic set_idling(input bit src_flag, input bit sink_flag);
    in_valid = 1'b0;
    @(posedge clk);
    src_steady  = src_flag;
    sink_steady = sink_flag;
    @(negedge clk);
  endtask

  // one random request shaped by the current shadow count; a few are noise
  task automatic random_request(input int insert_pct, input int remove_pct);
    int          r;
    logic [1:0]  mode;
    logic [4:0]  pos;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      // noise: any mode, any position from 0 up to the list depth
      mode = 2'($urandom_range(0, 3));
      pos  = 5'($urandom_range(0, LIST_DEPTH));
    end else begin
      if (r < 5 + insert_pct) mode = pal_pkg::MODE_INSERT;
      else if (r < 5 + insert_pct + remove_pct) mode = pal_pkg::MODE_REMOVE;
      else mode = pal_pkg::MODE_READ;
      if ($urandom_range(0, 15) == 0) begin
        // broken position, often just past the end
        if ($urandom_range(0, 1) == 0) begin
          pos = 5'(shadow_count + int'(mode == pal_pkg::MODE_INSERT));
        end else begin
          pos = 5'($urandom_range(0, LIST_DEPTH));
        end
      end else if (mode == pal_pkg::MODE_INSERT) begin
        pos = 5'($urandom_range(0, shadow_count));
      end else begin
        pos = (shadow_count == 0) ? 5'd0 : 5'($urandom_range(0, shadow_count - 1));
      end
    end
    send_request(mode, pos, pick_entry());
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // empty-list corners, the four insert shapes, fill to full, then edges of a
  // full list
  task automatic test_directed_edges();
    int k;
    // empty list: emptiness reported ahead of any position check
    send_request(pal_pkg::MODE_READ, 5'd0, 32'd0);
    send_request(pal_pkg::MODE_REMOVE, 5'd16, 32'd0);
    send_request(MODE_SPARE, 5'd0, 32'hDEAD_BEEF);
    send_request(pal_pkg::MODE_INSERT, 5'd1, 32'h1111_1111);
    // first entry, append at the end, push in at the front, push in the middle
    send_request(pal_pkg::MODE_INSERT, 5'd0, 32'h0000_0000);
    send_request(pal_pkg::MODE_INSERT, 5'd1, 32'hFFFF_FFFF);
    send_request(pal_pkg::MODE_INSERT, 5'd0, 32'h5A5A_A5A5);
    send_request(pal_pkg::MODE_INSERT, 5'd2, 32'h1234_5678);
    // fill the rest at random valid positions
    for (k = 4; k < LIST_DEPTH; k++) begin
      send_request(pal_pkg::MODE_INSERT, 5'($urandom_range(0, k)), pick_entry());
    end
    // full list: fullness reported ahead of the position
    send_request(pal_pkg::MODE_INSERT, 5'd16, 32'hCAFE_F00D);
    send_request(pal_pkg::MODE_READ, 5'd15, 32'd0);
    send_request(pal_pkg::MODE_READ, 5'd16, 32'd0);
    send_request(pal_pkg::MODE_REMOVE, 5'd16, 32'd0);
    send_request(pal_pkg::MODE_REMOVE, 5'd15, 32'd0);
    send_request(pal_pkg::MODE_REMOVE, 5'd0, 32'd0);
    send_request(MODE_SPARE, 5'd3, 32'hFFFF_FFFF);
    wait_all_replies();
  endtask

  // receiver holds off a long time while the sender keeps offering, so the
  // block backs up and drops in_ready; then the sender waits for every reply
  task automatic test_output_backpressure();
    int k;
    in_valid = 1'b0;
    @(posedge clk);
    hold_request = HOLD_CYCLES;
    src_steady   = 1'b1;
    @(negedge clk);
    for (k = 0; k < 12; k++) begin
      random_request(35, 25);
    end
    wait_all_replies();
    set_idling(1'b0, 1'b0);
  endtask

  // phases that push the list toward full, toward empty, or keep it mixed,
  // with the idling style varying between phases
  task automatic test_random_mix();
    int phase;
    int k;
    int per_phase;
    int insert_pct;
    int remove_pct;
    per_phase = RANDOM_ITEMS / PHASE_COUNT;
    for (phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase % 3)
        0: begin insert_pct = 60; remove_pct = 15; end   // mostly filling
        1: begin insert_pct = 15; remove_pct = 60; end   // mostly draining
        default: begin insert_pct = 38; remove_pct = 35; end
      endcase
      set_idling(phase == 2 || phase == 6, phase == 4 || phase == 6);
      for (k = 0; k < per_phase; k++) begin
        random_request(insert_pct, remove_pct);
      end
      // sender pause halfway through the run
      if (phase == PHASE_COUNT / 2) wait_all_replies();
    end
    set_idling(1'b0, 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    test_directed_edges();
    test_output_backpressure();
    test_random_mix();

    // drain, then let any stray reply show itself
    wait_all_replies();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (awaited_replies.size() != 0) begin
      report_mismatch("replies never returned, count", 32'(awaited_replies.size()), 32'd0);
    end

    $display("requests: %0d (insert %0d, remove %0d, read %0d, unused %0d), checked %0d",
             accepted_count, mode_tally[0], mode_tally[1], mode_tally[2], mode_tally[3],
             replies_checked);
    $display("statuses: ok %0d, full %0d, empty %0d, bad position %0d; mismatches %0d",
             status_tally[0], status_tally[1], status_tally[2], status_tally[3], error_count);
    if (error_count == 0) begin
      $display("positional_array_list regression: pass");
    end else begin
      $display("positional_array_list regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/pal_pkg.sv
rtl/pal_decode.sv
rtl/positional_array_list.sv
tb/sv/tb_top.sv
